### hdl/modular_exponentiation_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for modular exponentiation
// Clocked on clk and disabled while arst_n is low; the using scope supplies both.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// Same-cycle implication
`define MEXP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int unsigned OPERAND_BITS_DEF = 32;
	localparam int unsigned MODULUS_RESET    = 7;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_REDUCE = 4'b0010,
		S_SQUARE = 4'b0100,
		S_MULT   = 4'b1000
	} mexp_state_t;

endpackage

### hdl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: one bit of y per cycle, MSB first,
// doubling the accumulator and adding x modulo m.
// ----------------------------------------------------------------------------
module mexp_mulmod import mexp_pkg::*; #(
	parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic [OPERAND_BITS-1:0] x,
	input  logic [OPERAND_BITS-1:0] y,
	input  logic [OPERAND_BITS-1:0] m,
	output logic                    done,
	output logic [OPERAND_BITS-1:0] product
);

	localparam int unsigned CNT_W = $clog2(OPERAND_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_BITS - 1);

	logic                    run_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [OPERAND_BITS-1:0] acc_q;
	logic [OPERAND_BITS-1:0] x_q;
	logic [OPERAND_BITS-1:0] y_q;
	logic [OPERAND_BITS-1:0] dbl;
	logic [OPERAND_BITS-1:0] acc_nxt;

	// (a + b) mod mm for a, b below mm
	function automatic logic [OPERAND_BITS-1:0] add_mod(
		input logic [OPERAND_BITS-1:0] a,
		input logic [OPERAND_BITS-1:0] b,
		input logic [OPERAND_BITS-1:0] mm
	);
		logic [OPERAND_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, mm}) begin
			s = s - {1'b0, mm};
		end
		return s[OPERAND_BITS-1:0];
	endfunction

	always_comb begin
		dbl     = add_mod(acc_q, acc_q, m);
		acc_nxt = y_q[OPERAND_BITS-1] ? add_mod(dbl, x_q, m) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (run_q) begin
			acc_q <= acc_nxt;
			y_q   <= {y_q[OPERAND_BITS-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

### hdl/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// base ** exponent mod modulus by square-and-multiply, MSB first.
//
// Command channel: base and exponent transfer on a clock edge with start
// high and busy low. The result appears on power_result for one cycle with
// done high; the receiver cannot stall it, so the block never waits on it.
// Configuration: modulus transfers when cfg_valid is high (cfg_ready is
// always high); write it only while busy is low and no result is pending.
// A modulus of 0 or 1 gives 0 in the cycle after the command.
// Sequence: the base is first reduced modulo the modulus (one quotient bit
// per cycle), then each modular product runs in the bit-serial multiplier;
// there is one square per exponent bit and one multiply per set bit.
// Items are handled one at a time. Reset sets the modulus to 7 and idles
// the block; no other state survives between items.
// ----------------------------------------------------------------------------
module modular_exponentiation_top import mexp_pkg::*; #(
	parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [OPERAND_BITS-1:0] base,
	input  logic [OPERAND_BITS-1:0] exponent,
	output logic                    done,
	output logic [OPERAND_BITS-1:0] power_result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [OPERAND_BITS-1:0] modulus
);

	localparam int unsigned CNT_W = $clog2(OPERAND_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_BITS - 1);

	mexp_state_t             state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    go_q;
	logic                    done_q;
	logic [OPERAND_BITS-1:0] mod_q;
	logic [OPERAND_BITS-1:0] num_q;
	logic [OPERAND_BITS-1:0] rem_q;
	logic [OPERAND_BITS-1:0] base_q;
	logic [OPERAND_BITS-1:0] exp_q;
	logic [OPERAND_BITS-1:0] r_q;
	logic                    sel_base_q;
	logic [OPERAND_BITS-1:0] result_q;

	logic [OPERAND_BITS:0]   rem_shift;
	logic [OPERAND_BITS:0]   rem_sub;
	logic [OPERAND_BITS-1:0] rem_nxt;
	logic                    mul_done;
	logic [OPERAND_BITS-1:0] mul_prod;
	logic                    accept;

	assign accept = start && !busy;

	// One restoring-division step of the base reduction
	always_comb begin
		rem_shift = {rem_q, num_q[OPERAND_BITS-1]};
		rem_sub   = rem_shift - {1'b0, mod_q};
		rem_nxt   = (rem_shift >= {1'b0, mod_q}) ? rem_sub[OPERAND_BITS-1:0]
		                                         : rem_shift[OPERAND_BITS-1:0];
	end

	mexp_mulmod #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.x      (r_q),
		.y      (sel_base_q ? base_q : r_q),
		.m      (mod_q),
		.done   (mul_done),
		.product(mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
			mod_q   <= OPERAND_BITS'(MODULUS_RESET);
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			if (cfg_valid) begin
				mod_q <= modulus;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mod_q <= OPERAND_BITS'(1)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_REDUCE;
							cnt_q   <= '0;
						end
					end
				end
				S_REDUCE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_SQUARE;
						cnt_q   <= '0;
						go_q    <= 1'b1;
					end
				end
				S_SQUARE: begin
					if (mul_done) begin
						if (exp_q[OPERAND_BITS-1]) begin
							state_q <= S_MULT;
							go_q    <= 1'b1;
						end else if (cnt_q == CNT_LAST) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							go_q  <= 1'b1;
						end
					end
				end
				S_MULT: begin
					if (mul_done) begin
						if (cnt_q == CNT_LAST) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= S_SQUARE;
							cnt_q   <= cnt_q + 1'b1;
							go_q    <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					num_q    <= base;
					exp_q    <= exponent;
					rem_q    <= '0;
					result_q <= '0;
				end
			end
			S_REDUCE: begin
				rem_q <= rem_nxt;
				num_q <= {num_q[OPERAND_BITS-2:0], 1'b0};
				if (cnt_q == CNT_LAST) begin
					base_q     <= rem_nxt;
					r_q        <= OPERAND_BITS'(1);
					sel_base_q <= 1'b0;
				end
			end
			S_SQUARE: begin
				if (mul_done) begin
					r_q <= mul_prod;
					if (exp_q[OPERAND_BITS-1]) begin
						sel_base_q <= 1'b1;
					end else begin
						// bit clear: this exponent bit is finished
						sel_base_q <= 1'b0;
						exp_q      <= {exp_q[OPERAND_BITS-2:0], 1'b0};
						result_q   <= mul_prod;
					end
				end
			end
			S_MULT: begin
				if (mul_done) begin
					r_q        <= mul_prod;
					sel_base_q <= 1'b0;
					exp_q      <= {exp_q[OPERAND_BITS-2:0], 1'b0};
					result_q   <= mul_prod;
				end
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign power_result = result_q;
	assign cfg_ready    = 1'b1;

endmodule

### hdl/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the command/result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_top_assert.svh"

module mexp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// A result never shows while an item is still in work
	`MEXP_ASSERT_NOW(a_done_idle, done, !busy, "done while busy")

	// An accepted command either starts work or completes at once
	`MEXP_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done, "command dropped")

	// Work ends only with a result
	`MEXP_ASSERT_NOW(a_end_has_result, $fell(busy), done, "busy fell without done")

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);
